// File: rtl/pp6hp_pkg.sv
// Shared types and constants of the binary PPM (P6) header parser.
package pp6hp_pkg;

   localparam int unsigned DIM_BITS_DEFAULT = 16;

   localparam int unsigned STATUS_BITS = 3;
   localparam int unsigned DATA_BITS   = 8;
   localparam int unsigned DIM_OUT_BITS = 16;
   localparam int unsigned RSP_DATA_BITS = 2 * DIM_OUT_BITS + DATA_BITS;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] ST_HEADER   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_COMPLETE = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_PIXEL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_ERROR    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_IGNORED  = 3'd4;

   // Characters the header grammar looks at
   localparam logic [DATA_BITS-1:0] CH_P     = 8'h50;
   localparam logic [DATA_BITS-1:0] CH_SIX   = 8'h36;
   localparam logic [DATA_BITS-1:0] CH_HASH  = 8'h23;
   localparam logic [DATA_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [DATA_BITS-1:0] CH_NINE  = 8'h39;
   localparam logic [DATA_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [DATA_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [DATA_BITS-1:0] CH_CR    = 8'h0D;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [DIM_OUT_BITS-1:0] image_width;
      logic [DIM_OUT_BITS-1:0] image_height;
      logic [DATA_BITS-1:0]    pixel_byte;
      logic                    last_pixel;
   } rsp_type;

endpackage

// File: rtl/ppm_p6_header_parser_unit.sv
// Top level of the binary PPM (P6) header parser and pixel forwarder.
//
// Feed a P6 file one byte per request (req_tdata = byte, req_tuser = start of
// file, which restarts the parse on that byte); every request yields exactly
// one response carrying a status (header byte, header complete, pixel byte,
// error, ignored byte), the width and height parsed so far (low 16 bits), the
// forwarded pixel byte and a last-pixel flag on rsp_tlast. The parse state
// updates from each accepted byte and the response lands in an output
// register, so a new request can be taken every cycle unless the skid register
// is full. A two-entry output stage (output register plus skid register)
// keeps req_tready high while one finished response waits on rsp_tready; the
// only other throughput limit is the skid register filling behind a stall.
// The pixel count is width*height, formed by one DIM_BITS x DIM_BITS multiply
// on the header-complete byte; the three color bytes per pixel are tracked
// by a small modulo-3 counter so no 3x product is needed. After an error all
// bytes are reported as ignored until the next start of file.
module ppm_p6_header_parser_unit #(
   parameter int unsigned DIM_BITS = pp6hp_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pp6hp_pkg::DATA_BITS-1:0]     req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] start_of_file
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] image_width, [31:16] image_height, [39:32] pixel_byte
   output logic [pp6hp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [pp6hp_pkg::STATUS_BITS-1:0]   rsp_tuser,  // [2:0] status
   output logic                                rsp_tlast   // last_pixel
);

   localparam int unsigned PIX_BITS = 2 * DIM_BITS;
   localparam int unsigned ACC_BITS = DIM_BITS + 4;

   // Parse phases
   localparam logic [2:0] PH_MAGIC0 = 3'd0;
   localparam logic [2:0] PH_MAGIC1 = 3'd1;
   localparam logic [2:0] PH_SEED   = 3'd2;
   localparam logic [2:0] PH_HEADER = 3'd3;
   localparam logic [2:0] PH_PIXELS = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;
   localparam logic [2:0] PH_FAILED = 3'd6;

   localparam logic [1:0] TOK_WIDTH  = 2'd0;
   localparam logic [1:0] TOK_HEIGHT = 2'd1;
   localparam logic [1:0] TOK_END    = 2'd3;
   localparam logic [1:0] SUB_LAST   = 2'd2;

   // Parse state
   logic [2:0]          phase_ff, phase_in;
   logic [1:0]          token_ff, token_in;
   logic                comment_ff, comment_in;
   logic                prev_ws_ff, prev_ws_in;
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [PIX_BITS-1:0] pix_left_ff, pix_left_in;
   logic [1:0]          sub_ff, sub_in;

   // Output stage
   pp6hp_pkg::rsp_type  out_ff, out_in;
   pp6hp_pkg::rsp_type  skid_ff, skid_in;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   pp6hp_pkg::rsp_type  new_rsp;

   logic                         accept;
   logic [pp6hp_pkg::DATA_BITS-1:0] b;
   logic                         sof;
   logic                         is_ws;
   logic                         is_digit;
   logic [DIM_BITS-1:0]          acc_sel;
   logic [ACC_BITS-1:0]          acc_next;
   logic [PIX_BITS-1:0]          pix_product;
   logic [DIM_BITS+15:0]         width_wide;
   logic [DIM_BITS+15:0]         height_wide;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign b          = req_tdata;
   assign sof        = req_tuser;

   assign is_ws = (b == pp6hp_pkg::CH_SPACE) ||
                  ((b >= pp6hp_pkg::CH_TAB) && (b <= pp6hp_pkg::CH_CR));
   assign is_digit = (b >= pp6hp_pkg::CH_ZERO) && (b <= pp6hp_pkg::CH_NINE);

   // One shared decimal digit unit: acc*10 + digit; the top four bits flag overflow
   assign acc_sel  = (token_ff == TOK_WIDTH) ? width_ff : height_ff;
   assign acc_next = ACC_BITS'({acc_sel, 3'b000}) + ACC_BITS'({acc_sel, 1'b0})
                   + ACC_BITS'(b - pp6hp_pkg::CH_ZERO);

   assign pix_product = PIX_BITS'(width_ff) * PIX_BITS'(height_ff);

   always_comb begin
      logic [2:0]  ph;
      logic        ok;
      logic [1:0]  tok_next;
      logic [pp6hp_pkg::STATUS_BITS-1:0] status;
      logic [pp6hp_pkg::DATA_BITS-1:0]   pix;
      logic        last;

      // A start-of-file mark restarts the parse on this very byte
      ph          = sof ? PH_MAGIC0 : phase_ff;
      phase_in    = ph;
      token_in    = sof ? 2'd0 : token_ff;
      comment_in  = sof ? 1'b0 : comment_ff;
      prev_ws_in  = sof ? 1'b0 : prev_ws_ff;
      width_in    = sof ? '0 : width_ff;
      height_in   = sof ? '0 : height_ff;
      pix_left_in = sof ? '0 : pix_left_ff;
      sub_in      = sof ? 2'd0 : sub_ff;
      ok          = 1'b1;
      tok_next    = token_ff;
      status      = pp6hp_pkg::ST_HEADER;
      pix         = '0;
      last        = 1'b0;

      case (ph)
         PH_MAGIC0: begin
            if (b == pp6hp_pkg::CH_P) begin
               phase_in = PH_MAGIC1;
            end else begin
               status   = pp6hp_pkg::ST_ERROR;
               phase_in = PH_FAILED;
            end
         end
         PH_MAGIC1: begin
            if (b == pp6hp_pkg::CH_SIX) begin
               phase_in = PH_SEED;
            end else begin
               status   = pp6hp_pkg::ST_ERROR;
               phase_in = PH_FAILED;
            end
         end
         PH_SEED: begin
            prev_ws_in = is_ws;
            phase_in   = PH_HEADER;
         end
         PH_HEADER: begin
            if (comment_ff) begin
               if (is_ws && (b != pp6hp_pkg::CH_SPACE)) begin
                  comment_in = 1'b0;
               end
            end else if (is_ws) begin
               if (!prev_ws_ff) begin
                  tok_next = token_ff + 2'd1;
               end
            end else if (b == pp6hp_pkg::CH_HASH) begin
               comment_in = 1'b1;
            end else if ((token_ff == TOK_WIDTH) || (token_ff == TOK_HEIGHT)) begin
               // Reject non-digits and values that do not fit DIM_BITS
               ok = is_digit && (acc_next[ACC_BITS-1:DIM_BITS] == '0);
               if (ok && (token_ff == TOK_WIDTH)) begin
                  width_in = acc_next[DIM_BITS-1:0];
               end
               if (ok && (token_ff == TOK_HEIGHT)) begin
                  height_in = acc_next[DIM_BITS-1:0];
               end
            end
            token_in   = tok_next;
            prev_ws_in = is_ws;
            if (!ok) begin
               status   = pp6hp_pkg::ST_ERROR;
               phase_in = PH_FAILED;
            end else if (tok_next == TOK_END) begin
               status      = pp6hp_pkg::ST_COMPLETE;
               pix_left_in = pix_product;
               sub_in      = 2'd0;
               phase_in    = (pix_product == '0) ? PH_DONE : PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            status = pp6hp_pkg::ST_PIXEL;
            pix    = b;
            if (sub_ff == SUB_LAST) begin
               sub_in      = 2'd0;
               pix_left_in = pix_left_ff - PIX_BITS'(1);
               if (pix_left_ff == PIX_BITS'(1)) begin
                  last     = 1'b1;
                  phase_in = PH_DONE;
               end
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         default: begin
            status = pp6hp_pkg::ST_IGNORED;
         end
      endcase

      width_wide  = {16'd0, width_in};
      height_wide = {16'd0, height_in};

      new_rsp.status       = status;
      new_rsp.image_width  = width_wide[15:0];
      new_rsp.image_height = height_wide[15:0];
      new_rsp.pixel_byte   = pix;
      new_rsp.last_pixel   = last;
   end

   // Output register with a skid register behind it
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_rsp;
            out_valid_in = accept;
         end
      end else if (accept) begin
         // Park the response while the output stalls
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC0;
         token_ff      <= 2'd0;
         comment_ff    <= 1'b0;
         prev_ws_ff    <= 1'b0;
         width_ff      <= '0;
         height_ff     <= '0;
         pix_left_ff   <= '0;
         sub_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            token_ff    <= token_in;
            comment_ff  <= comment_in;
            prev_ws_ff  <= prev_ws_in;
            width_ff    <= width_in;
            height_ff   <= height_in;
            pix_left_ff <= pix_left_in;
            sub_ff      <= sub_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.pixel_byte, out_ff.image_height, out_ff.image_width};
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last_pixel;

endmodule

// File: rtl/pp6hp_checker.sv
// Port-level checker for the P6 header parser, with its bind statement.
module pp6hp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [pp6hp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [pp6hp_pkg::STATUS_BITS-1:0]   rsp_tuser,
   input logic                                rsp_tlast
);

   // A stalled response holds its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // The last-pixel mark only rides on a pixel response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == pp6hp_pkg::ST_PIXEL)
      else $error("last mark on a non-pixel response");

   // Pixel byte field is zero unless a pixel is forwarded
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != pp6hp_pkg::ST_PIXEL) |-> rsp_tdata[39:32] == 8'd0)
      else $error("pixel byte set on a non-pixel response");

   // With a stalled output and a request taken, the skid fills and ready drops
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted beyond the output stage depth");

endmodule

bind ppm_p6_header_parser_unit pp6hp_checker u_pp6hp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/tb_ppm_p6_header_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the P6 header parser: byte stream in, predicted parse results out.
module tb_ppm_p6_header_parser_unit;
   import pp6hp_pkg::*;

   // Parser phases as tracked by the local predictor
   typedef enum logic [2:0] {
      PS_MAGIC0,
      PS_MAGIC1,
      PS_SEED,
      PS_HEADER,
      PS_PIXELS,
      PS_DONE,
      PS_FAILED
   } parse_phase_type;

   // One file byte waiting to be offered, with its pacing hints
   typedef struct packed {
      logic [DATA_BITS-1:0] data;
      logic                 sof;
      logic                 drain_first;  // hold until every parse result is back
      logic                 paced;        // allow random gaps after this byte
   } file_byte_type;

   localparam int unsigned DIM_LIMIT    = (1 << DIM_BITS_DEFAULT) - 1;
   localparam int unsigned RANDOM_BYTES = 1400;
   localparam int unsigned LONG_HOLD    = 80;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DATA_BITS-1:0]     req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;
   logic                     rsp_tlast;

   ppm_p6_header_parser_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Stimulus and expectations
   file_byte_type file_bytes_q[$];
   rsp_type     parse_outcome_q[$];
   logic        drain_next = 1'b0;
   logic        file_paced = 1'b1;
   int unsigned failures = 0;
   int unsigned outcome_count = 0;

   // Handshake events seen at the last rising edge, consumed at the falling edge
   logic        req_fired = 1'b0;
   logic        rsp_fired = 1'b0;

   // Predictor state, reset value of the block
   parse_phase_type parse_phase    = PS_MAGIC0;
   logic [1:0]      field_index    = 2'd0;
   logic            comment_open   = 1'b0;
   logic            last_was_space = 1'b0;
   logic [15:0]     width_sum      = '0;
   logic [15:0]     height_sum     = '0;
   longint unsigned payload_left   = 0;

   // Space, tab, LF, VT, FF and CR count as blanks
   function automatic logic is_blank(input logic [DATA_BITS-1:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   // Advance the predicted parse by one byte and return the expected result.
   function automatic rsp_type parse_byte(input logic [DATA_BITS-1:0] b, input logic sof);
      rsp_type     r;
      logic        blank;
      logic        ok;
      int unsigned acc;
      int unsigned grown;
      r = '0;
      r.status = ST_HEADER;
      if (sof) begin
         parse_phase    = PS_MAGIC0;
         field_index    = 2'd0;
         comment_open   = 1'b0;
         last_was_space = 1'b0;
         width_sum      = '0;
         height_sum     = '0;
         payload_left   = 0;
      end
      case (parse_phase)
         PS_MAGIC0: begin
            if (b == CH_P) parse_phase = PS_MAGIC1;
            else begin
               r.status = ST_ERROR;
               parse_phase = PS_FAILED;
            end
         end
         PS_MAGIC1: begin
            if (b == CH_SIX) parse_phase = PS_SEED;
            else begin
               r.status = ST_ERROR;
               parse_phase = PS_FAILED;
            end
         end
         PS_SEED: begin
            // The byte after the magic only seeds the blank flag
            last_was_space = is_blank(b);
            parse_phase = PS_HEADER;
         end
         PS_HEADER: begin
            blank = is_blank(b);
            ok = 1'b1;
            if (comment_open) begin
               // Only a blank other than space closes a comment
               if (blank && b != CH_SPACE) comment_open = 1'b0;
            end else if (blank) begin
               if (!last_was_space) field_index = field_index + 2'd1;
            end else if (b == CH_HASH) begin
               comment_open = 1'b1;
            end else if (field_index < 2'd2) begin
               if (b < CH_ZERO || b > CH_NINE) ok = 1'b0;
               else begin
                  acc = (field_index == 2'd0) ? 32'(width_sum) : 32'(height_sum);
                  grown = acc * 10 + 32'(b) - 32'(CH_ZERO);
                  // Keep the old value on overflow
                  if (grown > DIM_LIMIT) ok = 1'b0;
                  else if (field_index == 2'd0) width_sum = 16'(grown);
                  else height_sum = 16'(grown);
               end
            end
            last_was_space = blank;
            if (!ok) begin
               r.status = ST_ERROR;
               parse_phase = PS_FAILED;
            end else if (field_index == 2'd3) begin
               r.status = ST_COMPLETE;
               payload_left = 3 * longint'(width_sum) * longint'(height_sum);
               parse_phase = (payload_left != 0) ? PS_PIXELS : PS_DONE;
            end
         end
         PS_PIXELS: begin
            r.status = ST_PIXEL;
            r.pixel_byte = b;
            payload_left = payload_left - 1;
            if (payload_left == 0) begin
               r.last_pixel = 1'b1;
               parse_phase = PS_DONE;
            end
         end
         default: r.status = ST_IGNORED;
      endcase
      r.image_width = width_sum;
      r.image_height = height_sum;
      return r;
   endfunction

   // Mostly no gap or a short one, now and then a long one
   function automatic int unsigned pick_gap(input logic paced);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!paced || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_BITS-1:0] rand_blank();
      int unsigned v;
      v = $urandom_range(0, 5);
      return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
   endfunction

   // Any byte that is neither a blank nor a comment mark
   function automatic logic [DATA_BITS-1:0] rand_solid();
      logic [DATA_BITS-1:0] b;
      do b = 8'($urandom_range(33, 255)); while (b == CH_HASH);
      return b;
   endfunction

   function automatic logic [DATA_BITS-1:0] rand_non_digit();
      logic [DATA_BITS-1:0] b;
      do b = rand_solid(); while (b >= CH_ZERO && b <= CH_NINE);
      return b;
   endfunction

   // Small dimensions keep most payloads short
   function automatic int unsigned pick_dim();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r < 7) return $urandom_range(1, 3);
      return $urandom_range(4, 5);
   endfunction

   task automatic push_byte(input logic [DATA_BITS-1:0] b, input logic sof);
      file_byte_type fb;
      fb.data = b;
      fb.sof = sof;
      fb.drain_first = drain_next;
      fb.paced = file_paced;
      drain_next = 1'b0;
      file_bytes_q.push_back(fb);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   task automatic push_random(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Decimal number, sometimes with leading zeros
   task automatic push_number(input int unsigned value);
      int unsigned zeros;
      zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
      repeat (zeros) push_byte(CH_ZERO, 1'b0);
      push_text($sformatf("%0d", value));
   endtask

   // Blank run between tokens, optionally holding a comment after the blank run
   task automatic push_separator();
      logic [DATA_BITS-1:0] b;
      repeat ($urandom_range(1, 3)) push_byte(rand_blank(), 1'b0);
      if ($urandom_range(0, 99) < 15) begin
         push_byte(CH_HASH, 1'b0);
         repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom_range(0, 255));
            if (is_blank(b)) b = CH_SPACE;
            push_byte(b, 1'b0);
         end
         push_byte(CH_TAB + 8'($urandom_range(0, 4)), 1'b0);
         repeat ($urandom_range(0, 2)) push_byte(rand_blank(), 1'b0);
      end
   endtask

   task automatic push_magic_seed();
      push_byte(CH_P, 1'b1);
      push_byte(CH_SIX, 1'b0);
      push_byte(rand_blank(), 1'b0);
      if ($urandom_range(0, 3) == 0) push_separator();
   endtask

   task automatic push_header(input int unsigned w, input int unsigned h);
      push_magic_seed();
      push_number(w);
      push_separator();
      push_number(h);
      push_separator();
      // Maxval is never checked, so odd bytes are fine there
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_byte(rand_solid(), 1'b0);
      else push_number($urandom_range(1, DIM_LIMIT));
      push_byte(rand_blank(), 1'b0);
   endtask

   // One random file: mostly well formed, the rest broken, cut short or noise
   task automatic push_random_file();
      int unsigned kind;
      int unsigned w;
      int unsigned h;
      kind = $urandom_range(0, 99);
      file_paced = ($urandom_range(0, 4) != 0);
      drain_next = ($urandom_range(0, 19) == 0);
      if (kind < 68) begin
         w = pick_dim();
         h = pick_dim();
         push_header(w, h);
         push_random(3 * w * h);
         if ($urandom_range(0, 3) == 0) push_random($urandom_range(1, 4));
      end else if (kind < 78) begin
         // Empty image with one large dimension
         w = ($urandom_range(0, 3) == 0) ? DIM_LIMIT : $urandom_range(0, DIM_LIMIT);
         if ($urandom_range(0, 1)) push_header(w, 0);
         else push_header(0, w);
         if ($urandom_range(0, 1)) push_random($urandom_range(1, 3));
      end else if (kind < 88) begin
         case ($urandom_range(0, 5))
            0: begin
               do w = $urandom_range(0, 255); while (w == CH_P);
               push_byte(8'(w), 1'b1);
            end
            1: begin
               push_byte(CH_P, 1'b1);
               do w = $urandom_range(0, 255); while (w == CH_SIX);
               push_byte(8'(w), 1'b0);
            end
            2: begin
               push_magic_seed();
               if ($urandom_range(0, 1)) push_number($urandom_range(0, 999));
               push_byte(rand_non_digit(), 1'b0);
            end
            3: begin
               push_magic_seed();
               push_number($urandom_range(0, 999));
               push_separator();
               if ($urandom_range(0, 1)) push_number($urandom_range(0, 999));
               push_byte(rand_non_digit(), 1'b0);
            end
            4: begin
               push_magic_seed();
               push_number($urandom_range(DIM_LIMIT + 1, 999999));
            end
            default: begin
               push_magic_seed();
               push_number($urandom_range(0, 999));
               push_separator();
               push_number($urandom_range(DIM_LIMIT + 1, 999999));
            end
         endcase
         push_random($urandom_range(0, 4));
      end else if (kind < 94) begin
         // Restart in the middle of the payload, sometimes of a huge image
         if ($urandom_range(0, 1)) begin
            w = $urandom_range(1, DIM_LIMIT);
            h = $urandom_range(1, DIM_LIMIT);
         end else begin
            w = $urandom_range(1, 5);
            h = $urandom_range(3, 5);
         end
         push_header(w, h);
         push_random($urandom_range(1, 12));
      end else begin
         repeat ($urandom_range(1, 12))
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         failures++;
      end
   endtask

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Rising edge: check the result taken, then predict the request taken.
   // Both see the values from before the edge, so the order is fixed.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         req_fired = 1'b0;
         rsp_fired = 1'b0;
      end else begin
         rsp_fired = rsp_tvalid && rsp_tready;
         if (rsp_fired) begin
            got.status = rsp_tuser;
            got.image_width = rsp_tdata[15:0];
            got.image_height = rsp_tdata[31:16];
            got.pixel_byte = rsp_tdata[39:32];
            got.last_pixel = rsp_tlast;
            if (parse_outcome_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got status %0d",
                        $time, got.status);
               failures++;
            end else begin
               want = parse_outcome_q.pop_front();
               check_field("status", want.status, got.status);
               check_field("image_width", want.image_width, got.image_width);
               check_field("image_height", want.image_height, got.image_height);
               check_field("pixel_byte", want.pixel_byte, got.pixel_byte);
               check_field("last_pixel", want.last_pixel, got.last_pixel);
            end
            outcome_count++;
         end
         req_fired = req_tvalid && req_tready;
         if (req_fired) parse_outcome_q.push_back(parse_byte(req_tdata, req_tuser));
      end
   end

   // Sender: offer the next file byte at the falling edge once the last one went
   // through; hold a byte marked for draining until every result is back.
   int unsigned send_gap = 0;

   always @(negedge clock) begin
      file_byte_type next_byte;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_fired || !req_tvalid) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (file_bytes_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (file_bytes_q[0].drain_first && parse_outcome_q.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            next_byte = file_bytes_q.pop_front();
            req_tdata <= next_byte.data;
            req_tuser <= next_byte.sof;
            req_tvalid <= 1'b1;
            send_gap = pick_gap(next_byte.paced);
         end
      end
   end

   // Receiver: random back-pressure, switching between paced and free-running
   // stretches, plus a long hold now and then so the block fills and stalls
   // its input while the sender keeps offering.
   int unsigned hold_left      = 0;
   int unsigned long_hold_mark = 300;
   logic        recv_paced     = 1'b1;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fired && $urandom_range(0, 63) == 0) recv_paced = !recv_paced;
         if (hold_left == 0 && outcome_count >= long_hold_mark) begin
            hold_left = LONG_HOLD;
            long_hold_mark += 650;
         end else if (hold_left == 0 && rsp_fired) begin
            hold_left = pick_gap(recv_paced);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Directed cases, then random files; wait for the drain and report.
   initial begin
      int unsigned directed_len;
      // First byte after reset without a restart mark, then a 2x1 image and a trailing byte
      push_byte(CH_P, 1'b0);
      push_text("6\n2 1\n255\n");
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7E, 1'b0);
      // Bad first magic byte; the next byte is ignored
      push_byte(8'h51, 1'b1);
      push_byte(CH_SIX, 1'b0);
      // Bad second magic byte
      push_byte(CH_P, 1'b1);
      push_text("5");
      // Bad digit just below '0' in the width, just above '9' in the height
      push_byte(CH_P, 1'b1);
      push_text("6\n1/");
      push_byte(CH_P, 1'b1);
      push_text("6\n1 :");
      // Width and height overflow
      push_byte(CH_P, 1'b1);
      push_text("6\n65536");
      push_byte(CH_P, 1'b1);
      push_text("6\n1 70000");
      // Largest dimensions with an empty image, then a trailing byte
      push_byte(CH_P, 1'b1);
      push_text("6\n65535 0\n9\nz");
      push_byte(CH_P, 1'b1);
      push_text("6 0 65535 1 ");
      // Comments: a space keeps one open, CR closes it without moving the token
      push_byte(CH_P, 1'b1);
      push_text("6\n# x y\n1 #c d");
      push_byte(CH_CR, 1'b0);
      push_text("1\t\t255\n");
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      push_byte(8'h56, 1'b0);
      // Non-blank seed: the first blank skips the width; wait for all results first
      drain_next = 1'b1;
      push_byte(CH_P, 1'b1);
      push_text("6x 3 4 ");
      directed_len = file_bytes_q.size();

      while (file_bytes_q.size() < directed_len + RANDOM_BYTES) push_random_file();

      // Let the stimulus go out, then every result come back
      while (file_bytes_q.size() != 0 || req_tvalid) @(posedge clock);
      while (parse_outcome_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("ppm_p6_header_parser_unit verification clean");
      end else begin
         $display("ppm_p6_header_parser_unit verification failed");
      end
      $finish;
   end

   // Hang guard, far above the slowest legal run
   initial begin
      #10_000_000;
      $display("ppm_p6_header_parser_unit verification failed");
      $finish;
   end

endmodule
